// ===== hw/rtl/nls_pkg.sv =====
package nls_pkg;

  localparam int VALUE_WIDTH = 64;
  // Values never exceed 2^(VALUE_WIDTH-1)-1, so one bit less holds them.
  localparam int VAL_W = VALUE_WIDTH - 1;
  // Product of a value and a radix up to 36, plus a digit.
  localparam int MAC_W = VAL_W + 7;
  localparam int LIT_W = 63;

  localparam int RADIX_W = 6;
  localparam logic [RADIX_W-1:0] RADIX_DEC = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_E  = 8'h45;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_E  = 8'h65;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;

  localparam logic [6:0] XD_NONE = 7'd99;
  localparam logic [6:0] XD_LIMIT = 7'd36;

  localparam logic [7:0] E_DEC   = 8'h01;
  localparam logic [7:0] E_BASED = 8'h02;
  localparam logic [7:0] E_DIGIT = 8'h04;
  localparam logic [7:0] E_RADIX = 8'h08;
  localparam logic [7:0] E_NODIG = 8'h10;
  localparam logic [7:0] E_NOEXP = 8'h20;
  localparam logic [7:0] E_EXPOV = 8'h40;
  localparam logic [7:0] E_NEG   = 8'h80;

  localparam logic [1:0] KIND_INT   = 2'd0;
  localparam logic [1:0] KIND_FLOAT = 2'd1;
  localparam logic [1:0] KIND_BIG   = 2'd2;

  // Extended digit value: 0-9, a-z, A-Z map to 0..35, anything else to XD_NONE.
  function automatic logic [6:0] xdigit(input logic [7:0] c);
    logic [6:0] r;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      r = 7'(c - CH_ZERO);
    end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
      r = 7'(c - CH_LO_A + 8'd10);
    end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
      r = 7'(c - CH_UP_A + 8'd10);
    end else begin
      r = XD_NONE;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/numeric_literal_scanner_top.sv =====
// Output: the result is presented the cycle after the beat that ends the literal; after an
//   exponent, scaling first multiplies by ten (at most 18 times), then takes a step that
//   would pass the limit, if there is one, and then emits the result.
// Throughput: one character per cycle while in_stall is low; the scaling loop on the shared
//   multiply-accumulate unit holds the input until it emits, longer while the result slot is full.
// Reset: synchronous rst returns the scanner to idle with radix ten and no result pending.
module numeric_literal_scanner_top import nls_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       char_code,
  input  logic             end_of_input,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [LIT_W-1:0] literal_value,
  output logic [1:0]       literal_kind,
  output logic [7:0]       error_flags,
  output logic             terminator_consumed
);

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_DEC    = 3'd1;
  localparam logic [2:0] PH_BFIRST = 3'd2;
  localparam logic [2:0] PH_BASED  = 3'd3;
  localparam logic [2:0] PH_ESIGN  = 3'd4;
  localparam logic [2:0] PH_EFIRST = 3'd5;
  localparam logic [2:0] PH_EDIG   = 3'd6;
  localparam logic [2:0] PH_SCALE  = 3'd7;

  logic [2:0]         phase, phase_next;
  logic [VAL_W-1:0]   accum, accum_next;
  logic [VAL_W-1:0]   expo, expo_next;
  logic [RADIX_W-1:0] radix, radix_next;
  logic [7:0]         errs, errs_next;
  logic               ovf, ovf_next;

  logic [VAL_W-1:0]   mac_a, mac_res;
  logic [RADIX_W-1:0] mac_base, mac_digit;
  logic               mac_ok;

  logic               emit, emit_cons;
  logic [VAL_W-1:0]   emit_val;
  logic [1:0]         emit_kind;

  logic               out_free, in_accept, advance;

  logic               is_dec, is_x, is_dot, is_us, is_hash, is_e, is_plus, is_minus;
  logic [6:0]         xd;
  logic [RADIX_W-1:0] dec_digit;

  assign xd        = xdigit(char_code);
  assign is_dec    = !end_of_input && char_code >= CH_ZERO && char_code <= CH_NINE;
  assign is_x      = !end_of_input && xd < XD_LIMIT;
  assign is_dot    = !end_of_input && char_code == CH_DOT;
  assign is_us     = !end_of_input && char_code == CH_UNDER;
  assign is_hash   = !end_of_input && char_code == CH_HASH;
  assign is_e      = !end_of_input && (char_code == CH_LO_E || char_code == CH_UP_E);
  assign is_plus   = !end_of_input && char_code == CH_PLUS;
  assign is_minus  = !end_of_input && char_code == CH_MINUS;
  assign dec_digit = RADIX_W'(char_code - CH_ZERO);

  nls_mac u_mac (
    .a      (mac_a),
    .base   (mac_base),
    .digit  (mac_digit),
    .result (mac_res),
    .ok     (mac_ok)
  );

  always_comb begin
    logic [VAL_W-1:0] end_val;
    end_val    = ovf ? '0 : accum;
    phase_next = phase;
    accum_next = accum;
    expo_next  = expo;
    radix_next = radix;
    errs_next  = errs;
    ovf_next   = ovf;
    emit       = 1'b0;
    emit_val   = '0;
    emit_kind  = KIND_INT;
    emit_cons  = 1'b0;
    mac_a      = accum;
    mac_base   = RADIX_DEC;
    mac_digit  = dec_digit;
    case (phase)
      PH_DEC: begin
        if (is_dec) begin
          if (!ovf) begin
            if (mac_ok) accum_next = mac_res;
            else ovf_next = 1'b1;
          end
        end else if (is_dot) begin
          emit      = 1'b1;
          emit_kind = KIND_FLOAT;
          emit_cons = 1'b1;
        end else if (is_us) begin
          emit      = 1'b1;
          emit_kind = KIND_BIG;
          emit_cons = 1'b1;
        end else begin
          if (ovf) errs_next = errs_next | E_DEC;
          ovf_next   = 1'b0;
          accum_next = end_val;
          if (is_hash) begin
            if (end_val < VAL_W'(RADIX_MIN) || end_val > VAL_W'(RADIX_MAX)) begin
              errs_next  = errs_next | E_RADIX;
              radix_next = RADIX_MAX;
            end else begin
              radix_next = end_val[RADIX_W-1:0];
            end
            accum_next = '0;
            phase_next = PH_BFIRST;
          end else if (is_e) begin
            expo_next  = '0;
            phase_next = PH_ESIGN;
          end else begin
            emit     = 1'b1;
            emit_val = end_val;
          end
        end
      end
      PH_BFIRST, PH_BASED: begin
        mac_base  = radix;
        mac_digit = xd[RADIX_W-1:0];
        if (is_x) begin
          if (xd >= 7'(radix)) begin
            errs_next = errs | E_DIGIT;
          end else if (!ovf) begin
            if (mac_ok) accum_next = mac_res;
            else ovf_next = 1'b1;
          end
          phase_next = PH_BASED;
        end else if (phase == PH_BFIRST) begin
          errs_next = errs | E_NODIG;
          emit      = 1'b1;
        end else if (is_us) begin
          emit      = 1'b1;
          emit_kind = KIND_BIG;
          emit_cons = 1'b1;
        end else if ((errs & E_DIGIT) != '0) begin
          emit = 1'b1;
        end else if (ovf) begin
          errs_next = errs | E_BASED;
          emit      = 1'b1;
        end else begin
          emit     = 1'b1;
          emit_val = accum;
        end
      end
      PH_ESIGN, PH_EFIRST, PH_EDIG: begin
        mac_a = expo;
        if (phase == PH_ESIGN && is_plus) begin
          phase_next = PH_EFIRST;
        end else if (phase == PH_ESIGN && is_minus) begin
          errs_next  = errs | E_NEG;
          accum_next = '0;
          phase_next = PH_EFIRST;
        end else if (is_dec) begin
          if (!ovf) begin
            if (mac_ok) expo_next = mac_res;
            else ovf_next = 1'b1;
          end
          phase_next = PH_EDIG;
        end else if (phase != PH_EDIG) begin
          errs_next = errs | E_NOEXP;
          emit      = 1'b1;
        end else begin
          // an exponent past the limit counts as zero, flagged only for a nonzero value
          if (accum != '0 && ovf) begin
            errs_next = errs | E_DEC;
            expo_next = '0;
          end
          ovf_next   = 1'b0;
          phase_next = PH_SCALE;
        end
      end
      PH_SCALE: begin
        mac_digit = '0;
        if (expo == '0 || accum == '0) begin
          emit     = 1'b1;
          emit_val = accum;
        end else if (mac_ok) begin
          accum_next = mac_res;
          expo_next  = expo - VAL_W'(1);
        end else begin
          errs_next  = errs | E_EXPOV;
          accum_next = '0;
        end
      end
      default: begin
        if (is_dec) begin
          accum_next = VAL_W'(dec_digit);
          expo_next  = '0;
          errs_next  = '0;
          ovf_next   = 1'b0;
          radix_next = RADIX_DEC;
          phase_next = PH_DEC;
        end else begin
          phase_next = PH_IDLE;
        end
      end
    endcase
    if (emit) phase_next = PH_IDLE;
  end

  assign out_free  = !out_valid || !out_stall;
  // hold the input while scaling, or when this beat ends a literal and the result slot is full
  assign in_stall  = (phase == PH_SCALE) || (emit && !out_free);
  assign in_accept = in_valid && !in_stall;
  assign advance   = (phase == PH_SCALE) ? (!emit || out_free) : in_accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      accum     <= '0;
      expo      <= '0;
      radix     <= RADIX_DEC;
      errs      <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        phase <= phase_next;
        accum <= accum_next;
        expo  <= expo_next;
        radix <= radix_next;
        errs  <= errs_next;
        ovf   <= ovf_next;
      end
      if (advance && emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      literal_value       <= LIT_W'(emit_val);
      literal_kind        <= emit_kind;
      error_flags         <= errs_next;
      terminator_consumed <= emit_cons;
    end
  end

endmodule

// ===== hw/rtl/nls_mac.sv =====
// Shared multiply-accumulate: result = a * base + digit, ok when within the value limit.
module nls_mac import nls_pkg::*; (
  input  logic [VAL_W-1:0]   a,
  input  logic [RADIX_W-1:0] base,
  input  logic [RADIX_W-1:0] digit,
  output logic [VAL_W-1:0]   result,
  output logic               ok
);

  logic [MAC_W-1:0] prod;

  assign prod   = MAC_W'(a) * MAC_W'(base) + MAC_W'(digit);
  assign result = prod[VAL_W-1:0];
  assign ok     = (prod[MAC_W-1:VAL_W] == '0);

endmodule
